/* hdl/lift_floor_stepper_sequencer_top_defines.svh */
// Assertion macros for the checker of the lift sequencer.
`ifndef LIFT_FLOOR_STEPPER_SEQUENCER_TOP_DEFINES_SVH
`define LIFT_FLOOR_STEPPER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LFSS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LFSS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lfss_pkg.sv */
`default_nettype none

package lfss_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_STEP,
      MODE_OFF,
      MODE_SETTLE
   } mode_type;

   typedef enum logic [1:0] {
      CSR_STEPS_PER_FLOOR = 2'd0,
      CSR_PHASE_TICKS     = 2'd1,
      CSR_SETTLE_TICKS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [11:0] steps_per_floor;
      logic [7:0]  phase_ticks;
      logic [15:0] settle_ticks;
   } lfss_cfg_type;

   typedef struct packed {
      logic [1:0]  floor_now;
      logic [1:0]  shown_floor;
      mode_type    mode;
      logic        going_down;
      logic [13:0] cycles_left;
      logic [1:0]  phase_index;
      logic [15:0] tick_count;
      logic        emergency_prev;
      logic        emergency_latched;
   } lfss_state_type;

   typedef struct packed {
      logic [3:0] coil_pattern;
      logic [1:0] display_floor;
      logic       busy_res;
   } lfss_result_type;

   localparam lfss_cfg_type CFG_RESET = '{
      steps_per_floor: 12'd1000,
      phase_ticks:     8'd4,
      settle_ticks:    16'd1000
   };

   localparam lfss_state_type STATE_RESET = '{
      floor_now:         2'd0,
      shown_floor:       2'd0,
      mode:              MODE_IDLE,
      going_down:        1'b0,
      cycles_left:       14'd0,
      phase_index:       2'd0,
      tick_count:        16'd0,
      emergency_prev:    1'b0,
      emergency_latched: 1'b0
   };

   // Full-step two-coil drive; the downward sequence walks this table backward.
   localparam logic [3:0] COIL_UP [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

endpackage

`default_nettype wire

/* hdl/lfss_step.sv */
`default_nettype none

module lfss_step
   import lfss_pkg::*;
(
   input  lfss_cfg_type    cfg,
   input  lfss_state_type  state_cur,
   input  logic [2:0]      call_buttons,
   input  logic            emergency_pressed,
   output lfss_state_type  state_next,
   output lfss_result_type result
);

   always_comb begin
      lfss_state_type s;
      logic [7:0]     hold;
      logic [11:0]    spf;
      logic           tgt_ok;
      logic [1:0]     tgt;
      logic [1:0]     floor_gap;
      logic [15:0]    tick_inc;
      logic [1:0]     phase_sel;
      logic [3:0]     coil;
      logic           busy;

      s         = state_cur;
      hold      = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
      spf       = (cfg.steps_per_floor == 12'd0) ? 12'd1 : cfg.steps_per_floor;
      tgt_ok    = 1'b0;
      tgt       = 2'd0;
      floor_gap = 2'd0;
      coil      = 4'h0;
      busy      = 1'b0;

      if (emergency_pressed && !s.emergency_prev) begin
         s.emergency_latched = 1'b1;
      end
      s.emergency_prev = emergency_pressed;

      // At idle a held emergency from an upper floor wins over the buttons.
      if (s.mode == MODE_IDLE) begin
         if (s.emergency_latched) begin
            s.emergency_latched = 1'b0;
            if (emergency_pressed && s.floor_now[1]) begin
               tgt_ok = 1'b1;
               tgt    = 2'd1;
            end
         end
         if (!tgt_ok) begin
            unique case (s.floor_now)
               2'd0: begin
                  priority if (call_buttons[0]) begin tgt_ok = 1'b1; tgt = 2'd1; end
                  else if (call_buttons[1])     begin tgt_ok = 1'b1; tgt = 2'd2; end
                  else if (call_buttons[2])     begin tgt_ok = 1'b1; tgt = 2'd3; end
                  else begin
                  end
               end
               2'd1: begin
                  priority if (call_buttons[1]) begin tgt_ok = 1'b1; tgt = 2'd2; end
                  else if (call_buttons[2])     begin tgt_ok = 1'b1; tgt = 2'd3; end
                  else begin
                  end
               end
               2'd2: begin
                  priority if (call_buttons[2]) begin tgt_ok = 1'b1; tgt = 2'd3; end
                  else if (call_buttons[0])     begin tgt_ok = 1'b1; tgt = 2'd1; end
                  else begin
                  end
               end
               2'd3: begin
                  priority if (call_buttons[1]) begin tgt_ok = 1'b1; tgt = 2'd2; end
                  else if (call_buttons[0])     begin tgt_ok = 1'b1; tgt = 2'd1; end
                  else begin
                  end
               end
            endcase
         end
         if (tgt_ok) begin
            s.going_down  = (tgt < s.floor_now);
            floor_gap     = s.going_down ? (s.floor_now - tgt) : (tgt - s.floor_now);
            s.cycles_left = 14'(spf) * 14'(floor_gap);
            s.floor_now   = tgt;
            s.phase_index = 2'd0;
            s.tick_count  = 16'd0;
            s.mode        = MODE_STEP;
         end
      end

      // The tick on which a move starts is already a stepping tick.
      tick_inc  = s.tick_count + 16'd1;
      phase_sel = s.going_down ? (2'd3 - s.phase_index) : s.phase_index;

      unique case (s.mode)
         MODE_IDLE: begin
         end
         MODE_STEP: begin
            busy = 1'b1;
            coil = COIL_UP[phase_sel];
            if (tick_inc >= {8'd0, hold}) begin
               s.tick_count = 16'd0;
               if (s.phase_index == 2'd3) begin
                  s.phase_index = 2'd0;
                  if (s.cycles_left <= 14'd1) begin
                     s.cycles_left = 14'd0;
                     s.shown_floor = s.floor_now;
                     s.mode        = MODE_OFF;
                  end else begin
                     s.cycles_left = s.cycles_left - 14'd1;
                  end
               end else begin
                  s.phase_index = s.phase_index + 2'd1;
               end
            end else begin
               s.tick_count = tick_inc;
            end
         end
         MODE_OFF: begin
            busy = 1'b1;
            if (tick_inc >= {8'd0, hold}) begin
               s.tick_count = 16'd0;
               s.mode       = (cfg.settle_ticks != 16'd0) ? MODE_SETTLE : MODE_IDLE;
            end else begin
               s.tick_count = tick_inc;
            end
         end
         MODE_SETTLE: begin
            busy = 1'b1;
            if (tick_inc >= cfg.settle_ticks) begin
               s.tick_count = 16'd0;
               s.mode       = MODE_IDLE;
            end else begin
               s.tick_count = tick_inc;
            end
         end
      endcase

      state_next           = s;
      result.coil_pattern  = coil;
      result.display_floor = s.shown_floor;
      result.busy_res      = busy;
   end

endmodule

`default_nettype wire

/* hdl/lift_floor_stepper_sequencer_top.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  call_buttons[2:0], emergency_pressed
// rsp      out        rsp_valid/rsp_ready  coil_pattern[3:0], display_floor[1:0], busy_res
// csr      in         csr_we               csr_index[1:0], csr_wdata[15:0]
//
// While req_ready is high one item is accepted per cycle; its result is registered, then offered.
// The whole tick update is one pass of logic from the state register to its next value.
// A result register plus a one-entry skid buffer keep req_ready high while one result waits.
// req_ready drops only when both entries hold results that have not been taken.
// Synchronous reset restores the register defaults, idle at floor 0, and empties the outputs.
`default_nettype none

module lift_floor_stepper_sequencer_top
   import lfss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_call_buttons,
   input  logic        req_emergency_pressed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_coil_pattern,
   output logic [1:0]  rsp_display_floor,
   output logic        rsp_busy_res,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   lfss_cfg_type    cfg_ff;
   lfss_cfg_type    cfg_in;
   lfss_state_type  state_ff;
   lfss_state_type  state_in;
   lfss_result_type step_result;
   lfss_result_type out_ff;
   lfss_result_type out_in;
   lfss_result_type skid_ff;
   lfss_result_type skid_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   logic            accept;
   logic            take;

   lfss_step u_step (
      .cfg               (cfg_ff),
      .state_cur         (state_ff),
      .call_buttons      (req_call_buttons),
      .emergency_pressed (req_emergency_pressed),
      .state_next        (state_in),
      .result            (step_result)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = out_valid_ff && rsp_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEPS_PER_FLOOR: cfg_in.steps_per_floor = csr_wdata[11:0];
            CSR_PHASE_TICKS:     cfg_in.phase_ticks     = csr_wdata[7:0];
            CSR_SETTLE_TICKS:    cfg_in.settle_ticks    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The skid entry is always older than a new item, so it drains first.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = step_result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         state_ff      <= STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_coil_pattern  = out_ff.coil_pattern;
   assign rsp_display_floor = out_ff.display_floor;
   assign rsp_busy_res      = out_ff.busy_res;

endmodule

`default_nettype wire

/* hdl/lfss_checker.sv */
`default_nettype none
`include "lift_floor_stepper_sequencer_top_defines.svh"

module lfss_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_coil_pattern,
   input wire logic       rsp_busy_res
);

   logic coil_on;
   logic coil_legal;

   assign coil_on    = (rsp_coil_pattern != 4'h0);
   assign coil_legal = !coil_on || (rsp_coil_pattern == 4'h3) || (rsp_coil_pattern == 4'h6) ||
                       (rsp_coil_pattern == 4'hC) || (rsp_coil_pattern == 4'h9);

   // A driven coil only appears while the car is busy.
   `LFSS_ASSERT_NOW(a_coil_implies_busy, rsp_valid && coil_on, rsp_busy_res, "coil without busy")

   // Only rest or a two-coil full-step phase is ever driven.
   `LFSS_ASSERT_NOW(a_coil_legal, rsp_valid, coil_legal, "illegal coil pattern")

   // A stalled result item is still offered on the next cycle.
   `LFSS_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid, "result item dropped")

   // Reset leaves the result side empty.
   `LFSS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")

endmodule

bind lift_floor_stepper_sequencer_top lfss_checker u_lfss_checker (.*);

`default_nettype wire
